// ===== design/cfr_pkg.sv =====
// shared types, constants and the crc-8 byte update for the frame receiver
package cfr_pkg;

  // configuration register indexes
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_SOF_CODE    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_EOF_CODE    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MAX_LENGTH  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_DIAL_CODE   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_TOGGLE_CODE = 3'd4;

  // register reset values
  localparam logic [7:0] SOF_RESET    = 8'hAA;
  localparam logic [7:0] EOF_RESET    = 8'h55;
  localparam logic [3:0] MAXLEN_RESET = 4'd8;
  localparam logic [7:0] DIAL_RESET   = 8'h01;
  localparam logic [7:0] TOGGLE_RESET = 8'h02;

  // hard limit on payload length and crc polynomial
  localparam logic [3:0] MAX_PAYLOAD = 4'd8;
  localparam logic [7:0] CRC_POLY    = 8'h07;

  typedef enum logic [2:0] {
    PH_WAIT    = 3'd0,
    PH_TYPE    = 3'd1,
    PH_LEN     = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CRC     = 3'd4,
    PH_EOF     = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    ST_DIAL        = 3'd0,
    ST_TOGGLE      = 3'd1,
    ST_UNKNOWN     = 3'd2,
    ST_LEN_BAD     = 3'd3,
    ST_CRC_BAD     = 3'd4,
    ST_MISSING_END = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0] sof_code;
    logic [7:0] eof_code;
    logic [3:0] max_length;
    logic [7:0] dial_code;
    logic [7:0] toggle_code;
  } cfg_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] type_code;
    logic [3:0] length;
    logic [7:0] value;
    logic       toggle_on;
  } result_t;

  // one byte through the msb-first crc-8 shift register
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== design/crc8_frame_receiver.sv =====
// top level of the crc-8 framed byte receiver
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o rx_byte_i
//   out      output     out_valid_o/out_stall_i status_o type_code_o length_o value_o toggle_on_o
//   cfg      input      cfg_we_i                cfg_idx_i cfg_wdata_i
//
// one byte per clock while the output is not stalled: each byte is held in the
// input register, the parser state and crc update are computed from it, and a
// frame result is loaded into the result register once its end-code byte moves on.
// asynchronous reset clears the parser and restores register defaults.
// a stalled output blocks the input only once the input register is also full.
module crc8_frame_receiver (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [cfr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [7:0]                  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  rx_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [2:0]                  status_o,
  output logic [7:0]                  type_code_o,
  output logic [3:0]                  length_o,
  output logic [7:0]                  value_o,
  output logic                        toggle_on_o
);

  cfr_pkg::cfg_t    cfg;
  cfr_pkg::result_t res_new;
  cfr_pkg::result_t res_out;
  logic             res_load;
  logic             res_ready;

  cfr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  cfr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .res_ready_i (res_ready),
    .res_load_o  (res_load),
    .res_o       (res_new)
  );

  cfr_result_reg u_res (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_load),
    .res_i       (res_new),
    .ready_o     (res_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  // result fields to ports
  assign status_o    = res_out.status;
  assign type_code_o = res_out.type_code;
  assign length_o    = res_out.length;
  assign value_o     = res_out.value;
  assign toggle_on_o = res_out.toggle_on;

`ifndef ASSERT_OFF
  // input backs up only behind a full, stalled result register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  // a result is never loaded over one that is still held
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_load && out_valid_o) |-> !out_stall_i)
    else $error("result overwritten while stalled");

  // payload value is only reported for dial and toggle results
  a_value_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && value_o != 8'd0) |->
      (status_o == cfr_pkg::ST_DIAL || status_o == cfr_pkg::ST_TOGGLE))
    else $error("payload value on an error result");

  // toggle flag belongs to a toggle result with its two-byte length
  a_toggle_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && toggle_on_o) |->
      (status_o == cfr_pkg::ST_TOGGLE && length_o == 4'd2))
    else $error("toggle flag on a non-toggle result");
`endif

endmodule

// ===== design/cfr_cfg_regs.sv =====
// configuration registers of the frame receiver
module cfr_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [cfr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [7:0]                  cfg_wdata_i,
  output cfr_pkg::cfg_t               cfg_o
);

  cfr_pkg::cfg_t cfg_q, cfg_d;

  // decode the write index, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        cfr_pkg::REG_SOF_CODE:    cfg_d.sof_code    = cfg_wdata_i;
        cfr_pkg::REG_EOF_CODE:    cfg_d.eof_code    = cfg_wdata_i;
        cfr_pkg::REG_MAX_LENGTH:  cfg_d.max_length  = cfg_wdata_i[3:0];
        cfr_pkg::REG_DIAL_CODE:   cfg_d.dial_code   = cfg_wdata_i;
        cfr_pkg::REG_TOGGLE_CODE: cfg_d.toggle_code = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sof_code    <= cfr_pkg::SOF_RESET;
      cfg_q.eof_code    <= cfr_pkg::EOF_RESET;
      cfg_q.max_length  <= cfr_pkg::MAXLEN_RESET;
      cfg_q.dial_code   <= cfr_pkg::DIAL_RESET;
      cfg_q.toggle_code <= cfr_pkg::TOGGLE_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/cfr_parser.sv =====
// input byte register and frame parsing state machine
module cfr_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfr_pkg::cfg_t    cfg_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       rx_byte_i,
  input  logic             res_ready_i,
  output logic             res_load_o,
  output cfr_pkg::result_t res_o
);

  logic                stage_vld_q, stage_vld_d;
  logic [7:0]          stage_byte_q;
  logic                advance;
  logic                in_take;

  cfr_pkg::phase_e     phase_q, phase_d;
  logic [7:0]          ftype_q, ftype_d;
  logic [3:0]          flen_q, flen_d;
  logic [3:0]          count_q, count_d;
  logic [7:0]          crc_q, crc_d;
  logic [7:0]          rcheck_q, rcheck_d;
  logic [7:0]          pay0_q, pay0_d;
  logic [7:0]          pay1_q, pay1_d;

  logic [3:0]          limit;
  logic [7:0]          crc_next;
  logic [3:0]          count_inc;
  cfr_pkg::status_e    status;

  // staged byte moves on when the result slot is free or draining
  assign advance    = stage_vld_q && res_ready_i;
  assign in_stall_o = stage_vld_q && !res_ready_i;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    stage_vld_d = stage_vld_q;
    if (in_take) begin
      stage_vld_d = 1'b1;
    end else if (advance) begin
      stage_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_vld_q <= 1'b0;
    end else begin
      stage_vld_q <= stage_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      stage_byte_q <= rx_byte_i;
    end
  end

  // shared helpers for the phase logic
  assign limit     = (cfg_i.max_length > cfr_pkg::MAX_PAYLOAD) ? cfr_pkg::MAX_PAYLOAD
                                                               : cfg_i.max_length;
  assign crc_next  = cfr_pkg::crc8_byte(crc_q, stage_byte_q);
  assign count_inc = count_q + 4'd1;

  // end-of-frame checks in priority order
  always_comb begin
    if (stage_byte_q != cfg_i.eof_code) begin
      status = cfr_pkg::ST_MISSING_END;
    end else if (crc_q != rcheck_q) begin
      status = cfr_pkg::ST_CRC_BAD;
    end else if (ftype_q == cfg_i.dial_code) begin
      status = (flen_q == 4'd1) ? cfr_pkg::ST_DIAL : cfr_pkg::ST_LEN_BAD;
    end else if (ftype_q == cfg_i.toggle_code) begin
      status = (flen_q == 4'd2) ? cfr_pkg::ST_TOGGLE : cfr_pkg::ST_LEN_BAD;
    end else begin
      status = cfr_pkg::ST_UNKNOWN;
    end
  end

  // next state and result for one staged byte
  always_comb begin
    phase_d    = phase_q;
    ftype_d    = ftype_q;
    flen_d     = flen_q;
    count_d    = count_q;
    crc_d      = crc_q;
    rcheck_d   = rcheck_q;
    pay0_d     = pay0_q;
    pay1_d     = pay1_q;
    res_load_o = 1'b0;

    res_o.status    = status;
    res_o.type_code = ftype_q;
    res_o.length    = flen_q;
    res_o.value     = (status == cfr_pkg::ST_DIAL || status == cfr_pkg::ST_TOGGLE)
                      ? pay0_q : 8'd0;
    res_o.toggle_on = (status == cfr_pkg::ST_TOGGLE) && (pay1_q != 8'd0);

    if (advance) begin
      case (phase_q)
        cfr_pkg::PH_TYPE: begin
          ftype_d = stage_byte_q;
          crc_d   = cfr_pkg::crc8_byte(8'd0, stage_byte_q);
          phase_d = cfr_pkg::PH_LEN;
        end
        cfr_pkg::PH_LEN: begin
          count_d = 4'd0;
          if (stage_byte_q > {4'd0, limit}) begin
            phase_d = cfr_pkg::PH_WAIT;
          end else begin
            flen_d  = stage_byte_q[3:0];
            crc_d   = crc_next;
            phase_d = (stage_byte_q[3:0] == 4'd0) ? cfr_pkg::PH_CRC : cfr_pkg::PH_PAYLOAD;
          end
        end
        cfr_pkg::PH_PAYLOAD: begin
          if (count_q == 4'd0) begin
            pay0_d = stage_byte_q;
          end else if (count_q == 4'd1) begin
            pay1_d = stage_byte_q;
          end
          crc_d   = crc_next;
          count_d = count_inc;
          if (count_inc >= flen_q) begin
            phase_d = cfr_pkg::PH_CRC;
          end
        end
        cfr_pkg::PH_CRC: begin
          rcheck_d = stage_byte_q;
          phase_d  = cfr_pkg::PH_EOF;
        end
        cfr_pkg::PH_EOF: begin
          res_load_o = 1'b1;
          count_d    = 4'd0;
          phase_d    = cfr_pkg::PH_WAIT;
        end
        default: begin
          phase_d = (stage_byte_q == cfg_i.sof_code) ? cfr_pkg::PH_TYPE : cfr_pkg::PH_WAIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= cfr_pkg::PH_WAIT;
      ftype_q  <= 8'd0;
      flen_q   <= 4'd0;
      count_q  <= 4'd0;
      crc_q    <= 8'd0;
      rcheck_q <= 8'd0;
      pay0_q   <= 8'd0;
      pay1_q   <= 8'd0;
    end else begin
      phase_q  <= phase_d;
      ftype_q  <= ftype_d;
      flen_q   <= flen_d;
      count_q  <= count_d;
      crc_q    <= crc_d;
      rcheck_q <= rcheck_d;
      pay0_q   <= pay0_d;
      pay1_q   <= pay1_d;
    end
  end

endmodule

// ===== design/cfr_result_reg.sv =====
// result register on the output channel
module cfr_result_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  cfr_pkg::result_t res_i,
  output logic             ready_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output cfr_pkg::result_t res_o
);

  logic             vld_q, vld_d;
  cfr_pkg::result_t res_q;

  // slot can take a new result when empty or when the current one leaves
  assign ready_o = !vld_q || !out_stall_i;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (vld_q && !out_stall_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign res_o       = res_q;

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the crc-8 frame receiver: random framed byte streams
module tb_top;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_BYTES = 88;
  localparam int NUM_PHASES  = 8;
  localparam logic [cfr_pkg::CfgIdxW-1:0] REG_UNUSED_FIRST = 3'd5;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [cfr_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [7:0]                  cfg_wdata_i;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic [7:0]                  rx_byte_i = 8'h00;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic [2:0]                  status_o;
  logic [7:0]                  type_code_o;
  logic [3:0]                  length_o;
  logic [7:0]                  value_o;
  logic                        toggle_on_o;

  crc8_frame_receiver dut (.*);

  // 4-unit clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // register copies
  logic [7:0] m_sof;
  logic [7:0] m_eof;
  logic [3:0] m_max_len;
  logic [7:0] m_dial;
  logic [7:0] m_toggle;

  // parser copy
  cfr_pkg::phase_e p_phase;
  logic [7:0]      p_type;
  logic [3:0]      p_len;
  logic [3:0]      p_count;
  logic [7:0]      p_crc;
  logic [7:0]      p_check;
  logic [7:0]      p_first;
  logic [7:0]      p_second;

  logic [7:0]       pending_bytes[$];
  cfr_pkg::result_t expected_reports[$];

  int  send_idle_pct = 0;
  int  stall_pct = 0;
  bit  in_taken = 1'b0;
  bit  out_taken = 1'b0;
  int  quiet_cycles = 0;
  int  mismatches = 0;
  int  bytes_sent = 0;
  int  reports_seen = 0;
  int  status_count[6];

  // bit-serial crc-8, poly x^8+x^2+x+1, msb first
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] r;
    logic       fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ data[i];
      r = {r[6:0], 1'b0} ^ (fb ? cfr_pkg::CRC_POLY : 8'h00);
    end
    return r;
  endfunction

  // accepted payload limit: smaller of register and hard cap
  function automatic logic [3:0] len_limit();
    return (m_max_len > cfr_pkg::MAX_PAYLOAD) ? cfr_pkg::MAX_PAYLOAD : m_max_len;
  endfunction

  // advance the parser copy by one byte, queue a report at the end-code position
  task automatic parse_byte(input logic [7:0] b);
    cfr_pkg::result_t rep;
    case (p_phase)
      cfr_pkg::PH_TYPE: begin
        p_type = b;
        p_crc = crc8_next(8'h00, b);
        p_phase = cfr_pkg::PH_LEN;
      end
      cfr_pkg::PH_LEN: begin
        if (b > {4'h0, len_limit()}) begin
          p_phase = cfr_pkg::PH_WAIT;
          p_count = '0;
        end else begin
          p_len = b[3:0];
          p_crc = crc8_next(p_crc, b);
          p_count = '0;
          p_phase = (p_len == 4'd0) ? cfr_pkg::PH_CRC : cfr_pkg::PH_PAYLOAD;
        end
      end
      cfr_pkg::PH_PAYLOAD: begin
        if (p_count == 4'd0) p_first = b;
        else if (p_count == 4'd1) p_second = b;
        p_crc = crc8_next(p_crc, b);
        p_count = p_count + 4'd1;
        if (p_count >= p_len) p_phase = cfr_pkg::PH_CRC;
      end
      cfr_pkg::PH_CRC: begin
        p_check = b;
        p_phase = cfr_pkg::PH_EOF;
      end
      cfr_pkg::PH_EOF: begin
        // missing end beats crc, crc beats type, type beats length
        if (b != m_eof) rep.status = cfr_pkg::ST_MISSING_END;
        else if (p_crc != p_check) rep.status = cfr_pkg::ST_CRC_BAD;
        else if (p_type == m_dial)
          rep.status = (p_len == 4'd1) ? cfr_pkg::ST_DIAL : cfr_pkg::ST_LEN_BAD;
        else if (p_type == m_toggle)
          rep.status = (p_len == 4'd2) ? cfr_pkg::ST_TOGGLE : cfr_pkg::ST_LEN_BAD;
        else rep.status = cfr_pkg::ST_UNKNOWN;
        rep.type_code = p_type;
        rep.length = p_len;
        rep.value = (rep.status == cfr_pkg::ST_DIAL || rep.status == cfr_pkg::ST_TOGGLE)
                    ? p_first : 8'h00;
        rep.toggle_on = (rep.status == cfr_pkg::ST_TOGGLE) && (p_second != 8'h00);
        expected_reports.push_back(rep);
        p_phase = cfr_pkg::PH_WAIT;
        p_count = '0;
      end
      default: begin
        p_phase = (b == m_sof) ? cfr_pkg::PH_TYPE : cfr_pkg::PH_WAIT;
      end
    endcase
  endtask

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // input driver and output stall: new transaction or idle at the falling edge
  always @(negedge clk_i) begin
    if (!in_valid_i || in_taken) begin
      if (rst_ni && pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        rx_byte_i <= pending_bytes.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= rst_ni && ($urandom_range(99) < stall_pct);
  end

  // monitor: check reports, feed accepted bytes to the parser copy, watchdog
  always @(posedge clk_i) begin
    cfr_pkg::result_t want;
    if (rst_ni) begin
      in_taken = in_valid_i && !in_stall_o;
      out_taken = out_valid_o && !out_stall_i;
      if (out_taken) begin
        if (expected_reports.size() == 0) begin
          $error("frame report with none expected: status %0d type 0x%0h",
                 status_o, type_code_o);
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          check_field("status", 8'(want.status), 8'(status_o));
          check_field("type_code", want.type_code, type_code_o);
          check_field("length", 8'(want.length), 8'(length_o));
          check_field("value", want.value, value_o);
          check_field("toggle_on", 8'(want.toggle_on), 8'(toggle_on_o));
          reports_seen++;
          status_count[want.status]++;
        end
      end
      if (in_taken) begin
        parse_byte(rx_byte_i);
        bytes_sent++;
      end
      if (in_taken || out_taken) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("no transaction for %0d cycles", STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // register write; the copy follows, unused indexes are dropped
  task automatic write_reg(input logic [cfr_pkg::CfgIdxW-1:0] idx, input logic [7:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      cfr_pkg::REG_SOF_CODE:    m_sof = data;
      cfr_pkg::REG_EOF_CODE:    m_eof = data;
      cfr_pkg::REG_MAX_LENGTH:  m_max_len = data[3:0];
      cfr_pkg::REG_DIAL_CODE:   m_dial = data;
      cfr_pkg::REG_TOGGLE_CODE: m_toggle = data;
      default: ;
    endcase
  endtask

  // queue one frame; payload past the first two bytes is random
  task automatic push_frame(input logic [7:0] kind, input logic [7:0] len,
                            input logic [7:0] p0, input logic [7:0] p1,
                            input bit bad_crc, input bit bad_end);
    logic [7:0] c;
    logic [7:0] d;
    pending_bytes.push_back(m_sof);
    pending_bytes.push_back(kind);
    pending_bytes.push_back(len);
    c = crc8_next(crc8_next(8'h00, kind), len);
    for (int i = 0; i < len; i++) begin
      d = (i == 0) ? p0 : (i == 1) ? p1 : 8'($urandom_range(255));
      c = crc8_next(c, d);
      pending_bytes.push_back(d);
    end
    pending_bytes.push_back(bad_crc ? c ^ 8'($urandom_range(1, 255)) : c);
    pending_bytes.push_back(bad_end ? m_eof ^ 8'($urandom_range(1, 255)) : m_eof);
  endtask

  // let the stream drain, then cover the block's own latency
  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_valid_i || expected_reports.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // stimulus
  initial begin
    int         sel;
    logic [7:0] kind;
    logic [7:0] len;
    logic [7:0] p1;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    m_sof = cfr_pkg::SOF_RESET;
    m_eof = cfr_pkg::EOF_RESET;
    m_max_len = cfr_pkg::MAXLEN_RESET;
    m_dial = cfr_pkg::DIAL_RESET;
    m_toggle = cfr_pkg::TOGGLE_RESET;
    p_phase = cfr_pkg::PH_WAIT;
    p_type = '0;
    p_len = '0;
    p_count = '0;
    p_crc = '0;
    p_check = '0;
    p_first = '0;
    p_second = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph != 0) wait_drained();
      // register settings, extremes first
      case (ph)
        0: ;
        1: begin
          write_reg(cfr_pkg::REG_SOF_CODE, 8'h00);
          write_reg(cfr_pkg::REG_EOF_CODE, 8'hFF);
          write_reg(cfr_pkg::REG_MAX_LENGTH, {4'($urandom_range(15)), 4'd0});
          write_reg(cfr_pkg::REG_DIAL_CODE, 8'h00);
          write_reg(cfr_pkg::REG_TOGGLE_CODE, 8'hFF);
        end
        2: begin
          // dial and toggle share a code, length cap above the hard limit
          write_reg(cfr_pkg::REG_SOF_CODE, 8'hFF);
          write_reg(cfr_pkg::REG_EOF_CODE, 8'h00);
          write_reg(cfr_pkg::REG_MAX_LENGTH, 8'h0F);
          write_reg(cfr_pkg::REG_DIAL_CODE, 8'h5A);
          write_reg(cfr_pkg::REG_TOGGLE_CODE, 8'h5A);
          for (int k = 0; k < 3; k++)
            write_reg(REG_UNUSED_FIRST + 3'(k), 8'($urandom_range(255)));
        end
        4: begin
          write_reg(cfr_pkg::REG_MAX_LENGTH, 8'd1);
          write_reg(cfr_pkg::REG_SOF_CODE, 8'($urandom_range(255)));
        end
        default: begin
          write_reg(cfr_pkg::REG_SOF_CODE, 8'($urandom_range(255)));
          write_reg(cfr_pkg::REG_EOF_CODE, 8'($urandom_range(255)));
          write_reg(cfr_pkg::REG_MAX_LENGTH, 8'($urandom_range(255)));
          write_reg(cfr_pkg::REG_DIAL_CODE, 8'($urandom_range(255)));
          write_reg(cfr_pkg::REG_TOGGLE_CODE, 8'($urandom_range(255)));
        end
      endcase

      // handshake pressure: none, sender idle, receiver stall, both
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 86; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 86; end
        default: begin send_idle_pct = 31; stall_pct = 31; end
      endcase

      if (ph == 0) begin
        // good dial with top value
        push_frame(m_dial, 8'd1, 8'hFF, 8'h00, 1'b0, 1'b0);
        // length over the cap: silent drop
        pending_bytes.push_back(m_sof);
        pending_bytes.push_back(m_dial);
        pending_bytes.push_back(8'd9);
        // zero length, unknown type
        push_frame(8'h00, 8'd0, 8'h00, 8'h00, 1'b0, 1'b0);
        // start code as payload, toggle off
        push_frame(m_toggle, 8'd2, m_sof, 8'h00, 1'b0, 1'b0);
        // bad crc and bad end together: missing end wins
        push_frame(8'hFF, 8'd0, 8'h00, 8'h00, 1'b1, 1'b1);
      end

      // random frames, mostly well formed, with noise between them
      while (pending_bytes.size() < PHASE_BYTES) begin
        sel = $urandom_range(99);
        kind = (sel < 40) ? m_dial : (sel < 80) ? m_toggle : 8'($urandom_range(255));
        sel = $urandom_range(99);
        if (sel < 65)
          len = (kind == m_dial) ? 8'd1 : (kind == m_toggle) ? 8'd2
              : 8'($urandom_range(len_limit()));
        else if (sel < 92) len = 8'($urandom_range(len_limit()));
        else len = 8'($urandom_range(15));
        p1 = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255));
        push_frame(kind, len, 8'($urandom_range(255)), p1,
                   $urandom_range(9) == 0, $urandom_range(9) == 0);
        if ($urandom_range(3) == 0)
          repeat ($urandom_range(1, 3)) pending_bytes.push_back(8'($urandom_range(255)));
        // occasional lone start code breaks the next frame
        if ($urandom_range(19) == 0) pending_bytes.push_back(m_sof);
      end
    end

    wait_drained();
    if (expected_reports.size() != 0) begin
      $error("%0d frame reports never arrived", expected_reports.size());
      mismatches++;
    end
    $display("%0d bytes over %0d register settings, %0d frame reports checked",
             bytes_sent, NUM_PHASES, reports_seen);
    $display("by status: dial %0d, toggle %0d, unknown %0d, bad length %0d",
             status_count[cfr_pkg::ST_DIAL], status_count[cfr_pkg::ST_TOGGLE],
             status_count[cfr_pkg::ST_UNKNOWN], status_count[cfr_pkg::ST_LEN_BAD]);
    $display("  bad crc %0d, no end %0d",
             status_count[cfr_pkg::ST_CRC_BAD], status_count[cfr_pkg::ST_MISSING_END]);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
